@@ sv/text_console_writer_top_assert.svh @@
// Assertion macros for the text console writer checker.
// Depends on nothing; included by the checker file.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer check failed");

// Next-cycle implication, disabled while reset is low
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer check failed");

`endif

@@ sv/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Cell value after reset: attribute zero, space
    localparam logic [CELL_W-1:0] RESET_CELL = {8'h00, CH_SPACE};

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SCROLL = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] read_data;
    } t_out_item;

    // What an accepted item asks of the screen store
    typedef struct packed {
        logic store;
        logic scroll;
    } t_cursor_ctl;

endpackage

@@ sv/tcw_cursor.sv @@
// Cursor registers (column, row, linear position) and their update per item.
// Depends on tcw_pkg.
module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_fire,
    input  tcw_pkg::t_in_item                     i_item,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       o_pos,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       o_next_pos,
    output tcw_pkg::t_cursor_ctl                  o_ctl
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic              last_col;
    logic              last_row;
    logic [ADDR_W-1:0] line_start;

    assign last_col   = (r_col == COL_W'(COLUMNS - 1));
    assign last_row   = (r_row == ROW_W'(ROWS - 1));
    assign line_start = r_pos - ADDR_W'(r_col);

    // Next cursor for the item on the input
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_pos = r_pos;
        o_ctl = '0;
        if (i_fire) begin
            case (i_item.op)
                OP_WRITE: begin
                    if (i_item.char_code == CH_NEWLINE) begin
                        n_col = '0;
                        if (last_row) begin
                            o_ctl.scroll = 1'b1;
                            n_pos = line_start;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                            n_pos = line_start + ADDR_W'(COLUMNS);
                        end
                    end else if (i_item.char_code == CH_RETURN) begin
                        n_col = '0;
                        n_pos = line_start;
                    end else begin
                        o_ctl.store = 1'b1;
                        if (last_col) begin
                            n_col = '0;
                            if (last_row) begin
                                o_ctl.scroll = 1'b1;
                                n_pos = line_start;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                                n_pos = r_pos + ADDR_W'(1);
                            end
                        end else begin
                            n_col = r_col + COL_W'(1);
                            n_pos = r_pos + ADDR_W'(1);
                        end
                    end
                end
                OP_CLEAR: begin
                    n_col = '0;
                    n_row = '0;
                    n_pos = '0;
                end
                OP_SCROLL: begin
                    o_ctl.scroll = 1'b1;
                    if (r_row != '0) begin
                        n_row = r_row - ROW_W'(1);
                        n_pos = r_pos - ADDR_W'(COLUMNS);
                    end
                end
                default: begin
                    // read leaves the cursor alone
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pos <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_pos <= n_pos;
        end
    end

    assign o_pos      = r_pos;
    assign o_next_pos = n_pos;

endmodule

@@ sv/text_console_writer_top.sv @@
// Top level of the text console writer: screen store, sweep engine, handshakes.
// Depends on tcw_pkg and tcw_cursor.
//
//  channel  direction  signals                             payload
//  in       input      i_in_valid / o_in_ready             i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_ready           o_out_item (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready           i_cfg_data (blank attribute)
//
// Character, newline and return items leave the block in idle unless they scroll; a read
// passes through a read state for the registered store read. Clear and scroll (also a
// newline or a wrap on the bottom row) accept the item, then sweep with one sweep
// cycle a cell on the single write port, and then write the last cell.
// After reset a clearing pass writes every cell before the first item is taken;
// cfg writes are taken throughout.
// The one-entry output register blocks new items only while it holds a stalled item.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcw_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcw_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [7:0]        r_blank_attr;

    logic              fire;
    logic              sweep;
    logic              cnt_last;
    logic              cnt_in_last_row;

    logic [ADDR_W-1:0] cur_pos;
    logic [ADDR_W-1:0] next_pos;
    t_cursor_ctl       ctl;

    // pending sweep write, registered in the cycle after the issue
    logic              r_wp_valid;
    logic [ADDR_W-1:0] r_wp_addr;
    logic              r_wp_blank, n_wp_blank;
    logic [CELL_W-1:0] r_wp_fill, n_wp_fill;

    // screen store
    logic [CELL_W-1:0] r_screen [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              r_rd_oor;
    logic              r_out_valid;
    t_out_item         r_out_item;

    assign fire            = i_in_valid && o_in_ready;
    assign cnt_last        = (r_cnt == ADDR_W'(CELLS - 1));
    assign cnt_in_last_row = (32'(r_cnt) >= CELLS - COLUMNS);

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (i_in_item),
        .o_pos      (cur_pos),
        .o_next_pos (next_pos),
        .o_ctl      (ctl)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (fire) begin
                    if (i_in_item.op == OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_in_item.op == OP_READ) begin
                        n_state = ST_READ;
                    end else if (ctl.scroll) begin
                        n_state = ST_SCROLL;
                    end
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_SCROLL, ST_CLEAR: begin
                if (cnt_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        sweep      = 1'b0;
        n_wp_fill  = {r_blank_attr, CH_SPACE};
        case (r_state)
            ST_INIT: begin
                sweep     = 1'b1;
                n_wp_fill = RESET_CELL;
            end
            ST_IDLE: o_in_ready = !r_wp_valid && (!r_out_valid || i_out_ready);
            ST_SCROLL, ST_CLEAR: sweep = 1'b1;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Sweep issue: blanks, or a move from one row below
    assign n_wp_blank = (r_state != ST_SCROLL) || cnt_in_last_row;
    assign n_cnt      = sweep ? (cnt_last ? '0 : r_cnt + ADDR_W'(1)) : r_cnt;

    // Store port selection
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(i_in_item.cell_index);
        if (sweep) begin
            mem_re    = !n_wp_blank;
            mem_raddr = ADDR_W'(32'(r_cnt) + COLUMNS);
        end else if (fire && i_in_item.op == OP_READ) begin
            mem_re = 1'b1;
        end
    end

    always_comb begin
        if (r_wp_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_wp_addr;
            mem_wdata = r_wp_blank ? r_wp_fill : r_rdata;
        end else begin
            mem_we    = fire && ctl.store;
            mem_waddr = cur_pos;
            mem_wdata = {i_in_item.attr, i_in_item.char_code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_screen[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_screen[mem_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_cnt        <= '0;
            r_wp_valid   <= 1'b0;
            r_blank_attr <= 8'h00;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_wp_valid <= sweep;
            if (i_cfg_valid) r_blank_attr <= i_cfg_data;
        end
    end

    // Sweep and read payload
    always_ff @(posedge i_clk) begin
        r_wp_addr  <= r_cnt;
        r_wp_blank <= n_wp_blank;
        r_wp_fill  <= n_wp_fill;
        if (fire) r_rd_oor <= !(32'(i_in_item.cell_index) < CELLS);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((fire && i_in_item.op != OP_READ) || r_state == ST_READ) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_in_item.op != OP_READ) begin
            r_out_item.cursor_pos <= POS_W'(next_pos);
            r_out_item.read_data  <= '0;
        end else if (r_state == ST_READ) begin
            r_out_item.cursor_pos <= POS_W'(cur_pos);
            r_out_item.read_data  <= r_rd_oor ? '0 : r_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

endmodule

@@ sv/tcw_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top_assert.svh.
`include "text_console_writer_top_assert.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input tcw_pkg::t_in_item   i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tcw_pkg::t_out_item  o_out_item,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [7:0]          i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    logic in_fire;
    logic cfg_seen;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_seen = i_cfg_valid && o_cfg_ready && (i_cfg_data == i_cfg_data);

    // stalled result holds
    `TCW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_item))

    // single result slot: no item taken while a result is stuck
    `TCW_ASSERT_NOW(a_no_take_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        !o_in_ready)

    // non-read items report in the next cycle
    `TCW_ASSERT_NEXT(a_result_next, i_clk, i_rst_n, in_fire && i_in_item.op != OP_READ,
        o_out_valid)

    // out-of-range read returns zero, via the read state and the output register
    `TCW_ASSERT_NOW(a_read_oor_zero, i_clk, i_rst_n,
        in_fire && i_in_item.op == OP_READ && !(32'(i_in_item.cell_index) < CELLS),
        ##2 (o_out_valid && o_out_item.read_data == '0))

    // cursor stays on the screen
    `TCW_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, o_out_valid || cfg_seen,
        !o_out_valid || (CELLS > 2048) || (32'(o_out_item.cursor_pos) < CELLS))

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

@@ test/tb_text_console_writer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer_top: directed table, then random text.
// Depends on tcw_pkg and the RTL of the block; results checked against a local screen mirror.
module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int COLS   = 80;
    localparam int ROWS_N = 25;
    localparam int CELLS  = COLS * ROWS_N;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 170;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    // Mirror of the screen store, cursor and blank attribute
    logic [15:0] screen_mirror [CELLS];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [7:0]  blank_attr_mirror;

    t_out_item console_reports_due [$];
    int        items_sent;
    int        results_seen;
    int        mismatches;

    typedef struct {
        t_op         op;
        logic [7:0]  char_code;
        logic [7:0]  attr;
        logic [10:0] cell_index;
        int          repeat_n;
        bit          fixed;
        logic [10:0] want_pos;
        logic [15:0] want_data;
    } t_directed_row;

    // Fixed expectations only where they are obvious; the rest come from the mirror
    t_directed_row directed [25] = '{
        '{OP_READ,   8'h00,      8'h00, 11'd0,    1,  1'b1, 11'd0,  16'h0020},
        '{OP_READ,   8'h00,      8'h00, 11'd1999, 1,  1'b1, 11'd0,  16'h0020},
        '{OP_READ,   8'h00,      8'h00, 11'd2047, 1,  1'b1, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd2000, 1,  1'b1, 11'd0,  16'h0000},
        '{OP_WRITE,  8'hFF,      8'hFF, 11'd2047, 1,  1'b1, 11'd1,  16'h0000},
        '{OP_WRITE,  8'h00,      8'h00, 11'd0,    1,  1'b1, 11'd2,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd0,    1,  1'b1, 11'd2,  16'hFFFF},
        '{OP_READ,   8'hFF,      8'hFF, 11'd1,    1,  1'b1, 11'd2,  16'h0000},
        '{OP_WRITE,  CH_RETURN,  8'hAA, 11'd0,    1,  1'b1, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd2,    1,  1'b1, 11'd0,  16'h0020},
        '{OP_WRITE,  CH_NEWLINE, 8'h00, 11'd0,    1,  1'b1, 11'd80, 16'h0000},
        '{OP_WRITE,  8'h41,      8'h1F, 11'd0,    1,  1'b1, 11'd81, 16'h0000},
        '{OP_SCROLL, 8'h00,      8'h00, 11'd0,    1,  1'b1, 11'd1,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd0,    1,  1'b0, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd1920, 1,  1'b0, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd1999, 1,  1'b0, 11'd0,  16'h0000},
        '{OP_CLEAR,  8'h00,      8'h00, 11'd0,    1,  1'b1, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd0,    1,  1'b0, 11'd0,  16'h0000},
        '{OP_SCROLL, 8'h00,      8'h00, 11'd0,    1,  1'b1, 11'd0,  16'h0000},
        '{OP_WRITE,  CH_NEWLINE, 8'h00, 11'd0,    24, 1'b0, 11'd0,  16'h0000},
        '{OP_WRITE,  8'h7E,      8'h81, 11'd0,    3,  1'b0, 11'd0,  16'h0000},
        '{OP_WRITE,  CH_NEWLINE, 8'h00, 11'd0,    1,  1'b0, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd1840, 1,  1'b0, 11'd0,  16'h0000},
        '{OP_SCROLL, 8'h00,      8'h00, 11'd0,    1,  1'b0, 11'd0,  16'h0000},
        '{OP_READ,   8'h00,      8'h00, 11'd1999, 1,  1'b0, 11'd0,  16'h0000}
    };

    text_console_writer_top #(
        .COLUMNS(COLS),
        .ROWS(ROWS_N)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic t_in_item console_item(t_op op, logic [7:0] ch, logic [7:0] at,
                                              logic [10:0] idx);
        t_in_item it;
        it.op         = op;
        it.char_code  = ch;
        it.attr       = at;
        it.cell_index = idx;
        return it;
    endfunction

    // Shift rows up one and blank the bottom row
    function automatic void scroll_mirror();
        for (int i = 0; i + COLS < CELLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen_mirror[i] = {blank_attr_mirror, CH_SPACE};
    endfunction

    function automatic void next_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS_N) begin
            scroll_mirror();
            cur_row = ROWS_N - 1;
        end
    endfunction

    // Apply one item to the mirror and return the report it should produce
    function automatic t_out_item advance_console(t_in_item it);
        t_out_item rep;
        rep.read_data = '0;
        case (it.op)
            OP_WRITE: begin
                if (it.char_code == CH_NEWLINE) begin
                    next_line();
                end else if (it.char_code == CH_RETURN) begin
                    cur_col = 0;
                end else begin
                    screen_mirror[cur_row * COLS + cur_col] = {it.attr, it.char_code};
                    cur_col++;
                    if (cur_col >= COLS) next_line();
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_mirror[i] = {blank_attr_mirror, CH_SPACE};
                cur_col = 0;
                cur_row = 0;
            end
            OP_SCROLL: begin
                scroll_mirror();
                if (cur_row > 0) cur_row--;
            end
            default: begin
                if (it.cell_index < CELLS) rep.read_data = screen_mirror[it.cell_index];
            end
        endcase
        rep.cursor_pos = POS_W'(cur_row * COLS + cur_col);
        return rep;
    endfunction

    // Offer one item, hold it until taken, then record its expected report
    task automatic send_item(input t_in_item it, input bit fixed, input t_out_item fixed_due);
        t_out_item due;
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        due = advance_console(it);
        console_reports_due.push_back(fixed ? fixed_due : due);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Blank attribute change, only once the block has drained
    task automatic write_blank_attr(input logic [7:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (console_reports_due.size() != 0 || !o_in_ready);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        blank_attr_mirror = value;
    endtask

    // Report checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (console_reports_due.size() == 0) begin
                $error("report with none expected: cursor_pos %0d read_data %h",
                       o_out_item.cursor_pos, o_out_item.read_data);
                mismatches++;
            end else begin
                want = console_reports_due.pop_front();
                if (o_out_item.cursor_pos !== want.cursor_pos) begin
                    $error("cursor_pos: expected %0d, got %0d",
                           want.cursor_pos, o_out_item.cursor_pos);
                    mismatches++;
                end
                if (o_out_item.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, o_out_item.read_data);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial begin : report_sink
        int stall;
        bit held_off;
        held_off = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_off && results_seen >= 300) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Stimulus
    initial begin : stimulus
        t_out_item   fixed_due;
        logic [7:0]  attr_plan [PHASES];
        int          phase_end;
        int          kind;
        int          n;
        int          k;
        int unsigned pos;
        logic [10:0] idx;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        items_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        cur_col = 0;
        cur_row = 0;
        blank_attr_mirror = 8'h00;
        foreach (screen_mirror[i]) screen_mirror[i] = RESET_CELL;
        attr_plan = '{8'h00, 8'h5A, 8'hFF, 8'hA5, 8'h00, 8'h00};
        attr_plan[4] = 8'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        write_blank_attr(8'hFF);
        foreach (directed[r]) begin
            fixed_due.cursor_pos = directed[r].want_pos;
            fixed_due.read_data  = directed[r].want_data;
            repeat (directed[r].repeat_n)
                send_item(console_item(directed[r].op, directed[r].char_code, directed[r].attr,
                                       directed[r].cell_index), directed[r].fixed, fixed_due);
        end

        // Random part: mostly lines of text, with reads, scrolls, clears and noise
        fixed_due = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_blank_attr(attr_plan[ph]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    // one line; now and then long enough to wrap
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                    : $urandom_range(0, 20);
                    repeat (n)
                        send_item(console_item(OP_WRITE, 8'($urandom), 8'($urandom),
                                               11'($urandom)), 1'b0, fixed_due);
                    k = $urandom_range(0, 9);
                    if (k >= 6 && k < 8)
                        send_item(console_item(OP_WRITE, CH_RETURN, 8'($urandom),
                                               11'($urandom)), 1'b0, fixed_due);
                    if (k < 8)
                        send_item(console_item(OP_WRITE, CH_NEWLINE, 8'($urandom),
                                               11'($urandom)), 1'b0, fixed_due);
                end else if (kind < 85) begin
                    // reads: near the cursor, anywhere, or past the screen
                    repeat ($urandom_range(1, 4)) begin
                        k = $urandom_range(0, 9);
                        pos = cur_row * COLS + cur_col;
                        n = $urandom_range(1, 4);
                        if (k < 5) idx = 11'((pos >= n) ? pos - n : 0);
                        else if (k < 9) idx = 11'($urandom_range(0, CELLS - 1));
                        else idx = 11'($urandom_range(CELLS, 2047));
                        send_item(console_item(OP_READ, 8'($urandom), 8'($urandom), idx),
                                  1'b0, fixed_due);
                    end
                end else if (kind < 93) begin
                    repeat ($urandom_range(1, 4))
                        send_item(console_item(t_op'($urandom_range(0, 3)), 8'($urandom),
                                               8'($urandom), 11'($urandom)), 1'b0, fixed_due);
                end else if (kind < 97) begin
                    send_item(console_item(OP_SCROLL, 8'($urandom), 8'($urandom),
                                           11'($urandom)), 1'b0, fixed_due);
                end else begin
                    send_item(console_item(OP_CLEAR, 8'($urandom), 8'($urandom),
                                           11'($urandom)), 1'b0, fixed_due);
                end
            end
        end

        // Drain, then watch a little longer for stray reports
        i_in_valid <= 1'b0;
        while (console_reports_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
